[sv/ue8_pkg.sv]
package ue8_pkg;

  // decoder modes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_HELD   = 2'd1;
  localparam logic [1:0] MODE_ESCAPE = 2'd2;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
  localparam logic [7:0] CHAR_U         = 8'h75;

  localparam int CODE_W   = 16;
  localparam int DIGITS_W = 3;

  // up to three result bytes from one input beat
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } group_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h37);
    end
    return h;
  endfunction

  // utf-8 encoding of a 16-bit code point, byte 0 sent first
  function automatic group_t utf8_encode(input logic [CODE_W-1:0] v);
    group_t g;
    g.last  = 1'b0;
    g.bytes = '0;
    if (v <= 16'd127) begin
      g.bytes[0] = v[7:0];
      g.cnt      = 2'd1;
    end else if (v <= 16'd2047) begin
      g.bytes[0] = {3'b110, v[10:6]};
      g.bytes[1] = {2'b10, v[5:0]};
      g.cnt      = 2'd2;
    end else begin
      g.bytes[0] = {4'b1110, v[15:12]};
      g.bytes[1] = {2'b10, v[11:6]};
      g.bytes[2] = {2'b10, v[5:0]};
      g.cnt      = 2'd3;
    end
    return g;
  endfunction

endpackage

[sv/ue8_decode.sv]
module ue8_decode import ue8_pkg::*; #(
  parameter int HEX_DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] s_byte,
  input  logic       s_last,
  output group_t     grp
);

  logic [1:0]          mode, mode_next;
  logic [DIGITS_W-1:0] digits, digits_next, dig_inc;
  logic [CODE_W-1:0]   code, code_next;
  logic                stopped, stopped_next;
  hex_t                hx;
  logic [1:0]          n;

  // next state and result group for the registered beat
  always_comb begin
    mode_next    = mode;
    digits_next  = digits;
    code_next    = code;
    stopped_next = stopped;
    grp          = '0;
    hx           = hex_decode(s_byte);
    dig_inc      = digits + 1'b1;
    n            = 2'd0;
    if (mode == MODE_ESCAPE) begin
      digits_next = dig_inc;
      if (!stopped && hx.ok) begin
        code_next = {code[CODE_W-5:0], hx.val};
      end else begin
        stopped_next = 1'b1;
      end
      if (dig_inc >= DIGITS_W'(HEX_DIGITS) || s_last) begin
        grp          = utf8_encode(code_next);
        mode_next    = MODE_NORMAL;
        digits_next  = '0;
        code_next    = '0;
        stopped_next = 1'b0;
      end
    end else if (mode == MODE_HELD && s_byte == CHAR_U) begin
      digits_next  = '0;
      code_next    = '0;
      stopped_next = 1'b0;
      if (s_last) begin
        grp       = utf8_encode('0);
        mode_next = MODE_NORMAL;
      end else begin
        mode_next = MODE_ESCAPE;
      end
    end else begin
      if (mode == MODE_HELD) begin
        grp.bytes[0] = CHAR_BACKSLASH;
        n            = 2'd1;
      end
      mode_next = MODE_NORMAL;
      if (s_byte == CHAR_BACKSLASH && !s_last) begin
        mode_next = MODE_HELD;
      end else begin
        grp.bytes[n] = s_byte;
        n            = n + 2'd1;
      end
      grp.cnt = n;
    end
    grp.last = s_last;
    // end of string returns everything to reset
    if (s_last) begin
      mode_next    = MODE_NORMAL;
      digits_next  = '0;
      code_next    = '0;
      stopped_next = 1'b0;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_NORMAL;
      digits  <= '0;
      code    <= '0;
      stopped <= 1'b0;
    end else if (step) begin
      mode    <= mode_next;
      digits  <= digits_next;
      code    <= code_next;
      stopped <= stopped_next;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    step && s_last |=> mode == MODE_NORMAL && digits == '0 && code == '0 && !stopped)
    else $error("state not cleared after end of string");

  a_digits_idle: assert property (@(posedge clk) disable iff (rst)
    mode != MODE_ESCAPE |-> digits == '0)
    else $error("digit count outside an escape");

  a_digits_bound: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_ESCAPE |-> digits < DIGITS_W'(HEX_DIGITS))
    else $error("escape ran past its digit count");

endmodule

[sv/unicode_escape_to_utf8.sv]
// path: input beat -> input register -> group register -> first output byte
// throughput: one output byte per cycle while out_ready is high; a beat that
//   yields n bytes holds the input until the single-byte serializer is done
// a held backslash or a partial escape yields no byte
// reset: synchronous, clears the decoder state, the input and output stages
module unicode_escape_to_utf8 import ue8_pkg::*; #(
  parameter int HEX_DIGITS = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       string_end
);

  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       step;
  logic       grp_free;
  group_t     grp_new;
  group_t     grp;
  logic       grp_valid;
  logic [1:0] grp_idx;

  // output side of the serializer
  assign out_valid  = grp_valid;
  assign out_byte   = grp.bytes[grp_idx];
  assign run_end    = (grp_idx == grp.cnt - 2'd1);
  assign string_end = run_end && grp.last;

  assign grp_free = !grp_valid || (out_ready && run_end);
  assign step     = s1_valid && grp_free;
  assign in_ready = !s1_valid || grp_free;

  ue8_decode #(.HEX_DIGITS(HEX_DIGITS)) u_decode (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .s_byte (s1_byte),
    .s_last (s1_last),
    .grp    (grp_new)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= in_byte;
      s1_last <= in_last;
    end
  end

  // result group register and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      grp_idx   <= 2'd0;
    end else if (grp_free) begin
      grp_valid <= step && (grp_new.cnt != 2'd0);
      grp_idx   <= 2'd0;
    end else if (out_ready) begin
      grp_idx <= grp_idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_free && step) begin
      grp <= grp_new;
    end
  end

  a_grp_index: assert property (@(posedge clk) disable iff (rst)
    grp_valid |-> grp.cnt != 2'd0 && grp_idx < grp.cnt)
    else $error("serializer index out of range");

  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !grp_free |=> s1_valid && $stable(s1_byte) && $stable(s1_last))
    else $error("stalled input beat lost");

  a_idx_adv: assert property (@(posedge clk) disable iff (rst)
    grp_valid && out_ready && !run_end |=> grp_valid && grp_idx == $past(grp_idx) + 2'd1)
    else $error("serializer did not advance");

endmodule
